FILE: rtl/core/spr_pkg.sv
// Package for the SVG path segment resolver: coordinate types, command and
// segment codes, item/result/state structs and saturating arithmetic.
// No dependencies.
package spr_pkg;

  // Internal coordinate width (signed fixed point, 12 fraction bits)
  localparam int CoordWidth = 32;
  // Width of the coordinate fields on the channels
  localparam int FieldWidth = 32;
  // Width of the intermediate sums used for saturation
  localparam int WideWidth  = 65;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [FieldWidth-1:0] field_t;
  typedef logic signed [WideWidth-1:0]  wide_t;
  typedef logic        [3:0]            mode_t;
  typedef logic        [2:0]            kind_t;

  // Path commands
  localparam mode_t MODE_MOVE   = 4'd0;
  localparam mode_t MODE_LINE   = 4'd1;
  localparam mode_t MODE_HORIZ  = 4'd2;
  localparam mode_t MODE_VERT   = 4'd3;
  localparam mode_t MODE_CUBIC  = 4'd4;
  localparam mode_t MODE_SCUBIC = 4'd5;
  localparam mode_t MODE_QUAD   = 4'd6;
  localparam mode_t MODE_SQUAD  = 4'd7;
  localparam mode_t MODE_CLOSE  = 4'd8;

  // Segment kinds
  localparam kind_t KIND_MOVE  = 3'd0;
  localparam kind_t KIND_LINE  = 3'd1;
  localparam kind_t KIND_CUBIC = 3'd2;
  localparam kind_t KIND_QUAD  = 3'd3;
  localparam kind_t KIND_CLOSE = 3'd4;
  localparam kind_t KIND_NONE  = 3'd5;

  typedef struct packed {
    mode_t  mode;
    logic   relative;
    logic   new_path;
    logic   continued;
    field_t ax;
    field_t ay;
    field_t bx;
    field_t by;
    field_t cx;
    field_t cy;
  } item_t;

  typedef struct packed {
    kind_t  kind;
    field_t p1x;
    field_t p1y;
    field_t p2x;
    field_t p2y;
    field_t p3x;
    field_t p3y;
  } result_t;

  typedef struct packed {
    coord_t pen_x;
    coord_t pen_y;
    coord_t sub_x;
    coord_t sub_y;
    coord_t cub_x;
    coord_t cub_y;
    coord_t quad_x;
    coord_t quad_y;
    logic   cubic_valid;
    logic   quad_valid;
    logic   halted;
  } state_t;

  // Sign-extend a coordinate to the wide intermediate
  function automatic wide_t widen(input coord_t v);
    return wide_t'({{(WideWidth-CoordWidth){v[CoordWidth-1]}}, v});
  endfunction

  // Clamp a wide value to the coordinate range
  function automatic coord_t clamp_coord(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (CoordWidth-1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi[CoordWidth-1:0];
    if (v < lo) return lo[CoordWidth-1:0];
    return v[CoordWidth-1:0];
  endfunction

  // Clamp a wide value to the field range
  function automatic field_t clamp_field(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (FieldWidth-1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi[FieldWidth-1:0];
    if (v < lo) return lo[FieldWidth-1:0];
    return v[FieldWidth-1:0];
  endfunction

  // Field to coordinate: sign-extend, then saturate
  function automatic coord_t in_coord(input field_t raw);
    return clamp_coord(wide_t'({{(WideWidth-FieldWidth){raw[FieldWidth-1]}}, raw}));
  endfunction

  // Coordinate to field: saturate to the field range
  function automatic field_t out_coord(input coord_t v);
    return clamp_field(widen(v));
  endfunction

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    return clamp_coord(widen(a) + widen(b));
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    return clamp_coord(widen(a) - widen(b));
  endfunction

  // Mirror a control point about the pen: 2*p - c, both steps saturated
  function automatic coord_t reflect(input coord_t p, input coord_t c);
    return sat_sub(sat_add(p, p), c);
  endfunction

endpackage

FILE: rtl/core/spr_ifs.sv
// Channel interfaces of the SVG path segment resolver: path groups in,
// resolved segments out. Depends on spr_pkg.
interface spr_in_if;
  logic               valid;
  logic               ready;
  spr_pkg::mode_t     mode;
  logic               relative;
  logic               new_path;
  logic               continued;
  spr_pkg::field_t    ax;
  spr_pkg::field_t    ay;
  spr_pkg::field_t    bx;
  spr_pkg::field_t    by;
  spr_pkg::field_t    cx;
  spr_pkg::field_t    cy;

  modport source (output valid, mode, relative, new_path, continued,
                  ax, ay, bx, by, cx, cy, input ready);
  modport sink   (input valid, mode, relative, new_path, continued,
                  ax, ay, bx, by, cx, cy, output ready);
endinterface

interface spr_out_if;
  logic               valid;
  logic               ready;
  spr_pkg::kind_t     kind;
  spr_pkg::field_t    p1x;
  spr_pkg::field_t    p1y;
  spr_pkg::field_t    p2x;
  spr_pkg::field_t    p2y;
  spr_pkg::field_t    p3x;
  spr_pkg::field_t    p3y;

  modport source (output valid, kind, p1x, p1y, p2x, p2y, p3x, p3y, input ready);
  modport sink   (input valid, kind, p1x, p1y, p2x, p2y, p3x, p3y, output ready);
endinterface

FILE: rtl/core/spr_step.sv
// Combinational resolver for one path group: absolute points, control
// point reflection, next path state and the segment. Depends on spr_pkg.
module spr_step (
  input  spr_pkg::item_t   item,
  input  spr_pkg::state_t  cur,
  output spr_pkg::state_t  nxt,
  output spr_pkg::result_t res
);

  spr_pkg::state_t st;
  spr_pkg::coord_t ax, ay, bx, by, cx, cy;
  spr_pkg::coord_t a1x, a1y, a2x, a2y, a3x, a3y, vy;
  spr_pkg::coord_t cub_rx, cub_ry, quad_rx, quad_ry;
  spr_pkg::coord_t r1x, r1y, r2x, r2y, r3x, r3y;
  spr_pkg::kind_t  kind;

  // Start of a new path clears everything, halt included
  assign st = item.new_path ? '0 : cur;

  // Bring the fields into the coordinate range
  assign ax = spr_pkg::in_coord(item.ax);
  assign ay = spr_pkg::in_coord(item.ay);
  assign bx = spr_pkg::in_coord(item.bx);
  assign by = spr_pkg::in_coord(item.by);
  assign cx = spr_pkg::in_coord(item.cx);
  assign cy = spr_pkg::in_coord(item.cy);

  // Absolute positions of the three pairs and of the vertical value
  assign a1x = item.relative ? spr_pkg::sat_add(st.pen_x, ax) : ax;
  assign a1y = item.relative ? spr_pkg::sat_add(st.pen_y, ay) : ay;
  assign a2x = item.relative ? spr_pkg::sat_add(st.pen_x, bx) : bx;
  assign a2y = item.relative ? spr_pkg::sat_add(st.pen_y, by) : by;
  assign a3x = item.relative ? spr_pkg::sat_add(st.pen_x, cx) : cx;
  assign a3y = item.relative ? spr_pkg::sat_add(st.pen_y, cy) : cy;
  assign vy  = item.relative ? spr_pkg::sat_add(st.pen_y, ax) : ax;

  // Reflected control points; fall back to the pen without a valid one
  assign cub_rx  = st.cubic_valid ? spr_pkg::reflect(st.pen_x, st.cub_x)  : st.pen_x;
  assign cub_ry  = st.cubic_valid ? spr_pkg::reflect(st.pen_y, st.cub_y)  : st.pen_y;
  assign quad_rx = st.quad_valid  ? spr_pkg::reflect(st.pen_x, st.quad_x) : st.pen_x;
  assign quad_ry = st.quad_valid  ? spr_pkg::reflect(st.pen_y, st.quad_y) : st.pen_y;

  // Command decode and state update
  always_comb begin
    nxt  = st;
    kind = spr_pkg::KIND_NONE;
    r1x  = '0;
    r1y  = '0;
    r2x  = '0;
    r2y  = '0;
    r3x  = '0;
    r3y  = '0;
    if (st.halted || item.mode > spr_pkg::MODE_CLOSE) begin
      // Unknown command or earlier halt: hold the path, report no segment
      nxt.halted = 1'b1;
    end else begin
      nxt.cubic_valid = 1'b0;
      nxt.quad_valid  = 1'b0;
      unique case (item.mode)
        spr_pkg::MODE_MOVE: begin
          kind = item.continued ? spr_pkg::KIND_LINE : spr_pkg::KIND_MOVE;
          if (!item.continued) begin
            nxt.sub_x = a1x;
            nxt.sub_y = a1y;
          end
          nxt.pen_x = a1x;
          nxt.pen_y = a1y;
          r1x = a1x;
          r1y = a1y;
        end
        spr_pkg::MODE_LINE: begin
          kind = spr_pkg::KIND_LINE;
          nxt.pen_x = a1x;
          nxt.pen_y = a1y;
          r1x = a1x;
          r1y = a1y;
        end
        spr_pkg::MODE_HORIZ: begin
          kind = spr_pkg::KIND_LINE;
          nxt.pen_x = a1x;
          r1x = a1x;
          r1y = st.pen_y;
        end
        spr_pkg::MODE_VERT: begin
          kind = spr_pkg::KIND_LINE;
          nxt.pen_y = vy;
          r1x = st.pen_x;
          r1y = vy;
        end
        spr_pkg::MODE_CUBIC: begin
          kind = spr_pkg::KIND_CUBIC;
          r1x = a1x;
          r1y = a1y;
          r2x = a2x;
          r2y = a2y;
          r3x = a3x;
          r3y = a3y;
          nxt.pen_x = a3x;
          nxt.pen_y = a3y;
          nxt.cub_x = a2x;
          nxt.cub_y = a2y;
          nxt.cubic_valid = 1'b1;
        end
        spr_pkg::MODE_SCUBIC: begin
          kind = spr_pkg::KIND_CUBIC;
          r1x = cub_rx;
          r1y = cub_ry;
          r2x = a1x;
          r2y = a1y;
          r3x = a2x;
          r3y = a2y;
          nxt.pen_x = a2x;
          nxt.pen_y = a2y;
          nxt.cub_x = a1x;
          nxt.cub_y = a1y;
          nxt.cubic_valid = 1'b1;
        end
        spr_pkg::MODE_QUAD: begin
          kind = spr_pkg::KIND_QUAD;
          r1x = a1x;
          r1y = a1y;
          r2x = a2x;
          r2y = a2y;
          nxt.pen_x  = a2x;
          nxt.pen_y  = a2y;
          nxt.quad_x = a1x;
          nxt.quad_y = a1y;
          nxt.quad_valid = 1'b1;
        end
        spr_pkg::MODE_SQUAD: begin
          kind = spr_pkg::KIND_QUAD;
          r1x = quad_rx;
          r1y = quad_ry;
          r2x = a1x;
          r2y = a1y;
          nxt.pen_x  = a1x;
          nxt.pen_y  = a1y;
          nxt.quad_x = quad_rx;
          nxt.quad_y = quad_ry;
          nxt.quad_valid = 1'b1;
        end
        default: begin
          // Close: return the pen to the subpath start
          kind = spr_pkg::KIND_CLOSE;
          nxt.pen_x = st.sub_x;
          nxt.pen_y = st.sub_y;
          r1x = st.sub_x;
          r1y = st.sub_y;
        end
      endcase
    end
  end

  // Pack the segment
  always_comb begin
    res.kind = kind;
    res.p1x  = spr_pkg::out_coord(r1x);
    res.p1y  = spr_pkg::out_coord(r1y);
    res.p2x  = spr_pkg::out_coord(r2x);
    res.p2y  = spr_pkg::out_coord(r2y);
    res.p3x  = spr_pkg::out_coord(r3x);
    res.p3y  = spr_pkg::out_coord(r3y);
  end

endmodule

FILE: rtl/core/svg_path_segment_resolver.sv
// Top level of the SVG path segment resolver: input register, path state,
// result register. Depends on spr_pkg, spr_ifs and spr_step.
//
//   Channel | Direction | Carries                                   | Transfer
//   in_ch   | sink      | mode, relative, new_path, continued, a..c | valid & ready
//   out_ch  | source    | kind, p1..p3                              | valid & ready
//
// One path group per cycle sustained while out_ch accepts segments; a segment is
// offered on out_ch once its group has passed the input register and then the
// result register. The state loop through spr_step into state_r sets the rate.
// Synchronous active-low reset clears the path state and both valid flags.
// A stalled output holds its segment; in_ch stays ready while the input
// register is empty or can move into the result register.
module svg_path_segment_resolver (
  input  logic       clk,
  input  logic       rst_n,
  spr_in_if.sink     in_ch,
  spr_out_if.source  out_ch
);

  logic             s1_valid_r, s1_valid_nxt;
  spr_pkg::item_t   s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  spr_pkg::result_t out_res_r;
  spr_pkg::state_t  state_r, state_nxt;
  spr_pkg::state_t  step_state;
  spr_pkg::result_t step_res;
  spr_pkg::item_t   in_item;
  logic             advance, in_xfer, s1_fire;

  // Gather the input payload
  assign in_item.mode      = in_ch.mode;
  assign in_item.relative  = in_ch.relative;
  assign in_item.new_path  = in_ch.new_path;
  assign in_item.continued = in_ch.continued;
  assign in_item.ax        = in_ch.ax;
  assign in_item.ay        = in_ch.ay;
  assign in_item.bx        = in_ch.bx;
  assign in_item.by        = in_ch.by;
  assign in_item.cx        = in_ch.cx;
  assign in_item.cy        = in_ch.cy;

  // Handshake: advance when the result register is free or being drained
  assign advance     = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  spr_step u_step (
    .item (s1_item_r),
    .cur  (state_r),
    .nxt  (step_state),
    .res  (step_res)
  );

  // Next values of control and state
  always_comb begin
    s1_valid_nxt  = in_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    state_nxt     = s1_fire ? step_state : state_r;
  end

  // Control and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_res_r <= step_res;
    end
  end

  // Drive the result channel
  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_res_r.kind;
  assign out_ch.p1x   = out_res_r.p1x;
  assign out_ch.p1y   = out_res_r.p1y;
  assign out_ch.p2x   = out_res_r.p2x;
  assign out_ch.p2y   = out_res_r.p2y;
  assign out_ch.p3x   = out_res_r.p3x;
  assign out_ch.p3y   = out_res_r.p3y;

endmodule

FILE: rtl/core/spr_checker.sv
// Port-level checks for the SVG path segment resolver and the bind that
// attaches them to the top level. Depends on spr_pkg.
module spr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input spr_pkg::kind_t  kind,
  input spr_pkg::field_t p1x,
  input spr_pkg::field_t p1y,
  input spr_pkg::field_t p2x,
  input spr_pkg::field_t p2y,
  input spr_pkg::field_t p3x,
  input spr_pkg::field_t p3y
);

  // Hold a stalled segment valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("segment dropped while stalled");

  // Hold a stalled segment's payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(kind) && $stable(p1x) && $stable(p1y)
      && $stable(p2x) && $stable(p2y) && $stable(p3x) && $stable(p3y))
    else $error("segment changed while stalled");

  // Only defined segment kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> kind <= spr_pkg::KIND_NONE)
    else $error("undefined segment kind");

  // Single-point and empty segments carry zero in the unused points
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == spr_pkg::KIND_MOVE || kind == spr_pkg::KIND_LINE
      || kind == spr_pkg::KIND_CLOSE || kind == spr_pkg::KIND_NONE)
      |-> p2x == '0 && p2y == '0 && p3x == '0 && p3y == '0)
    else $error("unused point nonzero");

  // Quad and halted segments leave the cubic end point zero; halted ones also p1
  a_none_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == spr_pkg::KIND_QUAD || kind == spr_pkg::KIND_NONE)
      |-> p3x == '0 && p3y == '0 && (kind == spr_pkg::KIND_QUAD
        || (p1x == '0 && p1y == '0)))
    else $error("unused point nonzero");

endmodule

bind svg_path_segment_resolver spr_checker u_spr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .p1x       (out_ch.p1x),
  .p1y       (out_ch.p1y),
  .p2x       (out_ch.p2x),
  .p2y       (out_ch.p2y),
  .p3x       (out_ch.p3x),
  .p3y       (out_ch.p3y)
);

FILE: verif/svg_path_segment_resolver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for svg_path_segment_resolver: drives path groups,
// predicts each resolved segment and checks it field by field.
// Depends on spr_pkg, spr_ifs and the resolver RTL.
module svg_path_segment_resolver_tb;

  localparam int             CYCLE_LIMIT     = 400000;
  localparam int             DRAIN_CYCLES    = 8;
  localparam int             STALL_CYCLES    = 80;
  localparam spr_pkg::mode_t MODE_UNKNOWN_LO = spr_pkg::MODE_CLOSE + 4'd1;
  localparam spr_pkg::mode_t MODE_UNKNOWN_HI = 4'hF;
  localparam spr_pkg::field_t COORD_MAX      = 32'sh7FFF_FFFF;
  localparam spr_pkg::field_t COORD_MIN      = 32'sh8000_0000;
  // 1.0 in Q19.12
  localparam spr_pkg::field_t ONE            = 32'sd4096;
  localparam spr_pkg::field_t SPAN           = 32'sd819200;

  // Pen, subpath start, last control points and their flags
  typedef struct packed {
    spr_pkg::coord_t pen_x, pen_y;
    spr_pkg::coord_t start_x, start_y;
    spr_pkg::coord_t cub_x, cub_y;
    spr_pkg::coord_t quad_x, quad_y;
    logic            cub_ok, quad_ok, halted;
  } pen_track_t;

  logic clk;
  logic rst_n;

  spr_in_if  in_ch ();
  spr_out_if out_ch ();

  svg_path_segment_resolver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pen_track_t       trk;
  spr_pkg::result_t expected_segments[$];
  int               cycle_count   = 0;
  int               errors        = 0;
  int               groups_sent   = 0;
  int               segs_checked  = 0;
  int               reflect_count = 0;
  int               held_total    = 0;
  int               kind_hits[0:5];
  bit               send_idle     = 1'b1;
  bit               recv_idle     = 1'b1;
  int               recv_hold     = 0;

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[svg_path_segment_resolver] ERROR");
      $finish;
    end
  end

  // Saturate a 64-bit sum to the coordinate range
  function automatic spr_pkg::coord_t fit_coord(input longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (spr_pkg::CoordWidth - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return spr_pkg::coord_t'(hi);
    if (v < lo) return spr_pkg::coord_t'(lo);
    return spr_pkg::coord_t'(v);
  endfunction

  function automatic spr_pkg::coord_t add_sat(input spr_pkg::coord_t a,
                                              input spr_pkg::coord_t b);
    return fit_coord(longint'(a) + longint'(b));
  endfunction

  // Mirror a control point about the pen, both steps saturated
  function automatic spr_pkg::coord_t mirror(input spr_pkg::coord_t p,
                                             input spr_pkg::coord_t c);
    return fit_coord(longint'(add_sat(p, p)) - longint'(c));
  endfunction

  // Advance the tracked path state by one group and return its segment.
  // Field and coordinate widths match, so no conversion is needed at the edges.
  function automatic spr_pkg::result_t resolve_group(input spr_pkg::item_t g);
    spr_pkg::result_t r;
    spr_pkg::coord_t  a1x, a1y, a2x, a2y, a3x, a3y, c1x, c1y;
    logic             keep_cub, keep_quad;
    r = '0;
    r.kind = spr_pkg::KIND_NONE;
    keep_cub = 1'b0;
    keep_quad = 1'b0;
    if (g.new_path) trk = '0;
    if (!trk.halted && g.mode > spr_pkg::MODE_CLOSE) trk.halted = 1'b1;
    if (!trk.halted) begin
      a1x = g.relative ? add_sat(trk.pen_x, g.ax) : g.ax;
      a1y = g.relative ? add_sat(trk.pen_y, g.ay) : g.ay;
      a2x = g.relative ? add_sat(trk.pen_x, g.bx) : g.bx;
      a2y = g.relative ? add_sat(trk.pen_y, g.by) : g.by;
      a3x = g.relative ? add_sat(trk.pen_x, g.cx) : g.cx;
      a3y = g.relative ? add_sat(trk.pen_y, g.cy) : g.cy;
      case (g.mode)
        spr_pkg::MODE_MOVE: begin
          r.kind = g.continued ? spr_pkg::KIND_LINE : spr_pkg::KIND_MOVE;
          if (!g.continued) begin
            trk.start_x = a1x;
            trk.start_y = a1y;
          end
          trk.pen_x = a1x;
          trk.pen_y = a1y;
          r.p1x = a1x;
          r.p1y = a1y;
        end
        spr_pkg::MODE_LINE: begin
          r.kind = spr_pkg::KIND_LINE;
          trk.pen_x = a1x;
          trk.pen_y = a1y;
          r.p1x = a1x;
          r.p1y = a1y;
        end
        spr_pkg::MODE_HORIZ: begin
          r.kind = spr_pkg::KIND_LINE;
          trk.pen_x = a1x;
          r.p1x = trk.pen_x;
          r.p1y = trk.pen_y;
        end
        spr_pkg::MODE_VERT: begin
          // V carries its value in ax
          r.kind = spr_pkg::KIND_LINE;
          trk.pen_y = g.relative ? add_sat(trk.pen_y, g.ax) : g.ax;
          r.p1x = trk.pen_x;
          r.p1y = trk.pen_y;
        end
        spr_pkg::MODE_CUBIC: begin
          r = '{spr_pkg::KIND_CUBIC, a1x, a1y, a2x, a2y, a3x, a3y};
          trk.pen_x = a3x;
          trk.pen_y = a3y;
          trk.cub_x = a2x;
          trk.cub_y = a2y;
          keep_cub = 1'b1;
        end
        spr_pkg::MODE_SCUBIC: begin
          c1x = trk.cub_ok ? mirror(trk.pen_x, trk.cub_x) : trk.pen_x;
          c1y = trk.cub_ok ? mirror(trk.pen_y, trk.cub_y) : trk.pen_y;
          if (trk.cub_ok) reflect_count++;
          r = '{spr_pkg::KIND_CUBIC, c1x, c1y, a1x, a1y, a2x, a2y};
          trk.pen_x = a2x;
          trk.pen_y = a2y;
          trk.cub_x = a1x;
          trk.cub_y = a1y;
          keep_cub = 1'b1;
        end
        spr_pkg::MODE_QUAD: begin
          r = '{spr_pkg::KIND_QUAD, a1x, a1y, a2x, a2y, 32'sd0, 32'sd0};
          trk.pen_x = a2x;
          trk.pen_y = a2y;
          trk.quad_x = a1x;
          trk.quad_y = a1y;
          keep_quad = 1'b1;
        end
        spr_pkg::MODE_SQUAD: begin
          c1x = trk.quad_ok ? mirror(trk.pen_x, trk.quad_x) : trk.pen_x;
          c1y = trk.quad_ok ? mirror(trk.pen_y, trk.quad_y) : trk.pen_y;
          if (trk.quad_ok) reflect_count++;
          r = '{spr_pkg::KIND_QUAD, c1x, c1y, a1x, a1y, 32'sd0, 32'sd0};
          trk.pen_x = a1x;
          trk.pen_y = a1y;
          trk.quad_x = c1x;
          trk.quad_y = c1y;
          keep_quad = 1'b1;
        end
        default: begin
          r.kind = spr_pkg::KIND_CLOSE;
          trk.pen_x = trk.start_x;
          trk.pen_y = trk.start_y;
          r.p1x = trk.pen_x;
          r.p1y = trk.pen_y;
        end
      endcase
      trk.cub_ok = keep_cub;
      trk.quad_ok = keep_quad;
    end
    return r;
  endfunction

  // Predict every group taken by the block
  always @(posedge clk) begin
    spr_pkg::result_t seg;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seg = resolve_group('{in_ch.mode, in_ch.relative, in_ch.new_path,
          in_ch.continued, in_ch.ax, in_ch.ay, in_ch.bx, in_ch.by,
          in_ch.cx, in_ch.cy});
      expected_segments.insert(expected_segments.size(), seg);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: segment %0d %s expected %h actual %h",
               $time, segs_checked, name, want, got);
    end
  endtask

  // Check each segment transfer against the oldest prediction
  always @(posedge clk) begin
    spr_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_segments.size() == 0) begin
        errors++;
        $display("%0t: segment expected none actual kind %0d",
                 $time, out_ch.kind);
      end else begin
        want = expected_segments.pop_front();
        compare_field("kind", 32'(want.kind), 32'(out_ch.kind));
        compare_field("p1x", want.p1x, out_ch.p1x);
        compare_field("p1y", want.p1y, out_ch.p1y);
        compare_field("p2x", want.p2x, out_ch.p2x);
        compare_field("p2y", want.p2y, out_ch.p2y);
        compare_field("p3x", want.p3x, out_ch.p3x);
        compare_field("p3y", want.p3y, out_ch.p3y);
        if (want.kind <= spr_pkg::KIND_NONE) kind_hits[want.kind]++;
      end
      segs_checked++;
    end
  end

  // Segment receiver: random stalls, plus long holds on request
  initial begin : receiver
    int w;
    int n;
    out_ch.ready = 1'b0;
    forever begin
      if (recv_hold > 0) begin
        n = recv_hold;
        recv_hold = 0;
        held_total += n;
        repeat (n) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end
      w = recv_idle ? int'($urandom_range(0, 10)) : 0;
      repeat (w) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && recv_hold == 0);
    end
  end

  // Offer one group, after a random gap when send_idle is set, and hold it until the transfer
  task automatic send_group(input spr_pkg::item_t g);
    int gap;
    gap = send_idle ? int'($urandom_range(0, 10)) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.mode      <= g.mode;
    in_ch.relative  <= g.relative;
    in_ch.new_path  <= g.new_path;
    in_ch.continued <= g.continued;
    in_ch.ax        <= g.ax;
    in_ch.ay        <= g.ay;
    in_ch.bx        <= g.bx;
    in_ch.by        <= g.by;
    in_ch.cx        <= g.cx;
    in_ch.cy        <= g.cy;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    groups_sent++;
  endtask

  // Drop valid, then wait for every predicted segment plus DRAIN_CYCLES more
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic spr_pkg::item_t make_group(input spr_pkg::mode_t m, input logic rel,
                                                input logic newp, input logic cont,
                                                input spr_pkg::field_t ax,
                                                input spr_pkg::field_t ay,
                                                input spr_pkg::field_t bx,
                                                input spr_pkg::field_t by,
                                                input spr_pkg::field_t cx,
                                                input spr_pkg::field_t cy);
    return '{m, rel, newp, cont, ax, ay, bx, by, cx, cy};
  endfunction

  // Mostly moderate coordinates, with full-range and extreme values mixed in
  function automatic spr_pkg::field_t pick_coord();
    case ($urandom_range(0, 9))
      0, 1: return spr_pkg::field_t'($urandom);
      2:    return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return spr_pkg::field_t'($urandom_range(0, 2 * SPAN)) - SPAN;
    endcase
  endfunction

  function automatic spr_pkg::item_t random_group();
    spr_pkg::item_t g;
    g.mode      = spr_pkg::mode_t'($urandom_range(spr_pkg::MODE_MOVE, spr_pkg::MODE_CLOSE));
    g.relative  = 1'($urandom_range(0, 1));
    g.new_path  = ($urandom_range(0, 39) == 0);
    g.continued = 1'($urandom_range(0, 1));
    g.ax = pick_coord();
    g.ay = pick_coord();
    g.bx = pick_coord();
    g.by = pick_coord();
    g.cx = pick_coord();
    g.cy = pick_coord();
    return g;
  endfunction

  // Every command, saturation at the extremes, reflection, close and halt
  task automatic test_directed_cases();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_group(make_group(spr_pkg::MODE_MOVE, 1'b0, 1'b1, 1'b0, COORD_MAX, COORD_MIN,
                          0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_LINE, 1'b1, 1'b0, 1'b0, COORD_MAX, COORD_MIN,
                          0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_HORIZ, 1'b1, 1'b0, 1'b0, COORD_MIN, 0,
                          0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_VERT, 1'b0, 1'b0, 1'b0, ONE, -ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_CUBIC, 1'b0, 1'b0, 1'b0, ONE, 2 * ONE, 3 * ONE,
                          -ONE, 4 * ONE, 4 * ONE));
    send_group(make_group(spr_pkg::MODE_SCUBIC, 1'b1, 1'b0, 1'b0, ONE, ONE, 2 * ONE,
                          0, 0, 0));
    // Extreme points, so the reflection in the following S saturates in both directions
    send_group(make_group(spr_pkg::MODE_SCUBIC, 1'b0, 1'b0, 1'b0, COORD_MIN, COORD_MAX,
                          COORD_MAX, COORD_MIN, 0, 0));
    send_group(make_group(spr_pkg::MODE_SCUBIC, 1'b0, 1'b0, 1'b0, ONE, ONE, -ONE, ONE,
                          0, 0));
    // No cubic control after a new path: first control is the pen
    send_group(make_group(spr_pkg::MODE_SCUBIC, 1'b0, 1'b1, 1'b0, ONE, ONE, 2 * ONE,
                          2 * ONE, 0, 0));
    send_group(make_group(spr_pkg::MODE_QUAD, 1'b0, 1'b0, 1'b0, 3 * ONE, ONE, 5 * ONE,
                          0, 0, 0));
    send_group(make_group(spr_pkg::MODE_SQUAD, 1'b1, 1'b0, 1'b0, ONE, -ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_SQUAD, 1'b0, 1'b0, 1'b0, COORD_MAX, COORD_MIN,
                          0, 0, 0, 0));
    // A line clears the quad flag, so T falls back to the pen
    send_group(make_group(spr_pkg::MODE_LINE, 1'b0, 1'b0, 1'b1, 2 * ONE, 2 * ONE,
                          0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_SQUAD, 1'b0, 1'b0, 1'b0, -ONE, -ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_MOVE, 1'b0, 1'b0, 1'b0, 7 * ONE, -7 * ONE,
                          0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_MOVE, 1'b1, 1'b0, 1'b1, ONE, ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_CLOSE, 1'b1, 1'b0, 1'b1, -1, -1, -1, -1, -1, -1));
    send_group(make_group(spr_pkg::MODE_CUBIC, 1'b1, 1'b0, 1'b1, -1, -1, -1, -1, -1, -1));
    // Unknown command halts until a new path
    send_group(make_group(MODE_UNKNOWN_LO, 1'b0, 1'b0, 1'b0, ONE, ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_LINE, 1'b0, 1'b0, 1'b0, ONE, ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_MOVE, 1'b0, 1'b0, 1'b0, ONE, ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_LINE, 1'b1, 1'b1, 1'b0, COORD_MIN, COORD_MAX,
                          0, 0, 0, 0));
    send_group(make_group(MODE_UNKNOWN_HI, 1'b0, 1'b1, 1'b0, ONE, ONE, 0, 0, 0, 0));
    send_group(make_group(spr_pkg::MODE_SQUAD, 1'b0, 1'b1, 1'b0, ONE, 2 * ONE,
                          0, 0, 0, 0));
    wait_drained();
  endtask

  // Hold the receiver off while groups keep coming, so the block backs up
  task automatic test_output_stall();
    spr_pkg::item_t g;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    recv_hold = STALL_CYCLES;
    g = random_group();
    g.mode = spr_pkg::MODE_MOVE;
    g.new_path = 1'b1;
    g.continued = 1'b0;
    send_group(g);
    repeat (30) send_group(random_group());
    wait_drained();
  endtask

  // Well-formed paths with random content; some halts and stray new paths
  task automatic test_random_paths(input int target);
    spr_pkg::item_t g;
    int             counted;
    int             len;
    bit             halted_tail;
    counted = 0;
    while (counted < target) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      g = random_group();
      g.new_path = 1'b1;
      if ($urandom_range(0, 9) != 0) begin
        g.mode = spr_pkg::MODE_MOVE;
        g.continued = 1'b0;
      end
      send_group(g);
      counted++;
      halted_tail = 1'b0;
      len = $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        g = random_group();
        if ($urandom_range(0, 99) < 4)
          g.mode = spr_pkg::mode_t'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
        send_group(g);
        if (g.new_path) halted_tail = 1'b0;
        if (!halted_tail) counted++;
        if (g.mode > spr_pkg::MODE_CLOSE) halted_tail = 1'b1;
        if (halted_tail && $urandom_range(0, 1)) break;
      end
    end
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    trk = '0;
    foreach (kind_hits[k]) kind_hits[k] = 0;
    in_ch.valid = 1'b0;
    in_ch.mode = spr_pkg::MODE_MOVE;
    in_ch.relative = 1'b0;
    in_ch.new_path = 1'b0;
    in_ch.continued = 1'b0;
    in_ch.ax = '0;
    in_ch.ay = '0;
    in_ch.bx = '0;
    in_ch.by = '0;
    in_ch.cx = '0;
    in_ch.cy = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_output_stall();
    test_random_paths(800);

    $display("Sent %0d path groups; checked %0d segments (%0d moves, %0d lines,",
             groups_sent, segs_checked, kind_hits[spr_pkg::KIND_MOVE],
             kind_hits[spr_pkg::KIND_LINE]);
    $display("  %0d cubics, %0d quads, %0d closes, %0d halted), %0d reflections,",
             kind_hits[spr_pkg::KIND_CUBIC], kind_hits[spr_pkg::KIND_QUAD],
             kind_hits[spr_pkg::KIND_CLOSE], kind_hits[spr_pkg::KIND_NONE],
             reflect_count);
    $display("  %0d receiver stall cycles", held_total);
    if (errors == 0) begin
      $display("[svg_path_segment_resolver] OK");
    end else begin
      $display("[svg_path_segment_resolver] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/spr_pkg.sv
rtl/core/spr_ifs.sv
rtl/core/spr_step.sv
rtl/core/svg_path_segment_resolver.sv
rtl/core/spr_checker.sv
verif/svg_path_segment_resolver_tb.sv
